// ===== rtl/rcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcw_pkg
// Widths, word types and per-item context for the room center residual unit.
// ----------------------------------------------------------------------------
package rcw_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;

  // offset magnitude times normal, both one bit wider than a word
  localparam int unsigned PW       = 2 * WORD_BITS + 2;
  localparam int unsigned HW       = PW + 1;
  // midpoint vector and its magnitude
  localparam int unsigned MW       = 2 * WORD_BITS - FRAC_BITS;
  localparam int unsigned AW       = MW - 1;
  localparam int unsigned POSW     = $clog2(AW);
  // normalized magnitudes keep their top bit at NORM_TOP
  localparam int unsigned NORM_TOP = 29;
  localparam int unsigned NW       = NORM_TOP + 1;
  // square root: one result bit per stage
  localparam int unsigned SQ_STEPS = NW + 1;
  localparam int unsigned SQW      = 2 * SQ_STEPS;
  localparam int unsigned RW       = SQ_STEPS;
  // divider: one quotient bit per stage
  localparam int unsigned QW       = FRAC_BITS + 1;
  localparam int unsigned NUMW     = NW + FRAC_BITS + 1;
  // unit direction, dot product, projection, error
  localparam int unsigned UW       = FRAC_BITS + 2;
  localparam int unsigned CPW      = WORD_BITS + UW;
  localparam int unsigned DSW      = CPW + 1;
  localparam int unsigned DTW      = DSW - FRAC_BITS;
  localparam int unsigned PPW      = DTW + UW;
  localparam int unsigned PJW      = PPW - FRAC_BITS;
  localparam int unsigned EW       = MW + 2;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] room_x;
    logic signed [WORD_BITS-1:0] room_y;
    logic signed [WORD_BITS-1:0] wall_a_nx;
    logic signed [WORD_BITS-1:0] wall_a_ny;
    logic signed [WORD_BITS-1:0] wall_a_offset;
    logic signed [WORD_BITS-1:0] wall_b_nx;
    logic signed [WORD_BITS-1:0] wall_b_ny;
    logic signed [WORD_BITS-1:0] wall_b_offset;
    logic signed [WORD_BITS-1:0] center_x;
    logic signed [WORD_BITS-1:0] center_y;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] error_x;
    logic signed [WORD_BITS-1:0] error_y;
    logic                        degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] room_x;
    logic signed [WORD_BITS-1:0] room_y;
    logic signed [WORD_BITS-1:0] center_x;
    logic signed [WORD_BITS-1:0] center_y;
    logic signed [MW-1:0]        mid_x;
    logic signed [MW-1:0]        mid_y;
    logic                        degenerate;
  } ctx_t;

endpackage

// ===== rtl/rcw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcw_in_if / rcw_out_if
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface rcw_in_if;
  import rcw_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rcw_out_if;
  import rcw_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/room_center_from_two_walls_residual_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// room_center_from_two_walls_residual_unit
// Residual between a room estimate and the pose derived from two walls.
// ----------------------------------------------------------------------------
// Takes one word per clock while the skid register is empty: room position,
// two wall planes and a cluster center, all signed Q16.16. Each plane with
// a positive offset is flipped, the midpoint vector 0.5*(|d1|*n1 + |d2|*n2)
// is formed, normalized to a unit direction, and the cluster center's part
// perpendicular to it is added to form the pose; the result is room minus
// pose, saturated to 32 bits. A zero midpoint vector gives degenerate = 1
// and zero errors. The datapath is a 63-stage pipeline that takes a new word
// every cycle while the skid register is empty. Most of that depth is the
// 31-stage pipelined square root (one root bit per stage) and the restoring
// divider that forms the unit direction (a setup stage and 17 quotient
// stages). A one-word skid register sits at the output: a result that is not
// taken when the pipeline advances parks there, and the whole pipeline and
// the input hold until that word leaves.
// ----------------------------------------------------------------------------
module room_center_from_two_walls_residual_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  rcw_in_if.sink           in_i,
  rcw_out_if.source        out_o
);
  import rcw_pkg::*;

  // stage map
  localparam int unsigned ST_MUL  = 0;
  localparam int unsigned ST_SUM  = 1;
  localparam int unsigned ST_RND  = 2;
  localparam int unsigned ST_ENC  = 3;
  localparam int unsigned ST_SHF  = 4;
  localparam int unsigned ST_SQR  = 5;
  localparam int unsigned ST_SSQ  = 6;
  localparam int unsigned ST_SQ0  = 7;
  localparam int unsigned ST_DSET = ST_SQ0 + SQ_STEPS;
  localparam int unsigned ST_USGN = ST_DSET + QW + 1;
  localparam int unsigned ST_CMUL = ST_USGN + 1;
  localparam int unsigned ST_DOT  = ST_CMUL + 1;
  localparam int unsigned ST_PMUL = ST_DOT + 1;
  localparam int unsigned ST_PROJ = ST_PMUL + 1;
  localparam int unsigned ST_ESUM = ST_PROJ + 1;
  localparam int unsigned ST_OUT  = ST_ESUM + 1;
  localparam int unsigned NST     = ST_OUT + 1;

  localparam logic signed [EW-1:0] SAT_HI =
    {{(EW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [EW-1:0] SAT_LO =
    {{(EW-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  function automatic logic signed [WORD_BITS:0] ext1(
    input logic signed [WORD_BITS-1:0] v
  );
    return {v[WORD_BITS-1], v};
  endfunction

  // --------------------------------------------------------------------------
  // Flow control: every stage advances together while the skid register is
  // empty; a result that is not taken when the pipe advances parks there.
  // --------------------------------------------------------------------------
  logic            adv;
  logic [NST-1:0]  v_q;
  logic            skid_v_q;
  out_item_t       skid_q;
  out_item_t       res_q;

  assign adv         = !skid_v_q;
  assign in_i.ready  = adv;
  assign out_o.valid = skid_v_q || v_q[NST-1];
  assign out_o.data  = skid_v_q ? skid_q : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      skid_v_q <= 1'b0;
    end else begin
      if (adv) begin
        v_q <= {v_q[NST-2:0], in_i.valid};
      end
      if (adv && v_q[NST-1] && !out_o.ready) begin
        skid_v_q <= 1'b1;
      end else if (skid_v_q && out_o.ready) begin
        skid_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v_q[NST-1] && !out_o.ready) begin
      skid_q <= res_q;
    end
  end

  // --------------------------------------------------------------------------
  // Context travels beside the arithmetic; the midpoint joins it at ST_RND.
  // --------------------------------------------------------------------------
  ctx_t ctx_q [0:ST_OUT-1];

  // --------------------------------------------------------------------------
  // ST_MUL: flip planes with positive offset, multiply |d| by the normal.
  // --------------------------------------------------------------------------
  logic                    a_pos, b_pos;
  logic signed [WORD_BITS:0] aa_w, ab_w, nax_w, nay_w, nbx_w, nby_w;
  logic signed [PW-1:0]    p1x_q, p1y_q, p2x_q, p2y_q;

  always_comb begin
    a_pos = !in_i.data.wall_a_offset[WORD_BITS-1] && (|in_i.data.wall_a_offset);
    b_pos = !in_i.data.wall_b_offset[WORD_BITS-1] && (|in_i.data.wall_b_offset);
    aa_w  = a_pos ? ext1(in_i.data.wall_a_offset) : -ext1(in_i.data.wall_a_offset);
    ab_w  = b_pos ? ext1(in_i.data.wall_b_offset) : -ext1(in_i.data.wall_b_offset);
    nax_w = a_pos ? -ext1(in_i.data.wall_a_nx) : ext1(in_i.data.wall_a_nx);
    nay_w = a_pos ? -ext1(in_i.data.wall_a_ny) : ext1(in_i.data.wall_a_ny);
    nbx_w = b_pos ? -ext1(in_i.data.wall_b_nx) : ext1(in_i.data.wall_b_nx);
    nby_w = b_pos ? -ext1(in_i.data.wall_b_ny) : ext1(in_i.data.wall_b_ny);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1x_q <= aa_w * nax_w;
      p1y_q <= aa_w * nay_w;
      p2x_q <= ab_w * nbx_w;
      p2y_q <= ab_w * nby_w;
      ctx_q[ST_MUL].room_x     <= in_i.data.room_x;
      ctx_q[ST_MUL].room_y     <= in_i.data.room_y;
      ctx_q[ST_MUL].center_x   <= in_i.data.center_x;
      ctx_q[ST_MUL].center_y   <= in_i.data.center_y;
      ctx_q[ST_MUL].mid_x      <= '0;
      ctx_q[ST_MUL].mid_y      <= '0;
      ctx_q[ST_MUL].degenerate <= 1'b0;
    end
  end

  // ST_SUM: add the two walls
  logic signed [HW-1:0] sx_q, sy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q <= HW'(p1x_q) + HW'(p2x_q);
      sy_q <= HW'(p1y_q) + HW'(p2y_q);
      ctx_q[ST_SUM] <= ctx_q[ST_MUL];
    end
  end

  // ST_RND: halve and round in one step: floor((s + 2^F) / 2^(F+1))
  logic [HW-1:0]        mxr_w, myr_w;
  logic signed [MW-1:0] mx_w, my_w;

  always_comb begin
    mxr_w = sx_q + (HW'(1) << FRAC_BITS);
    myr_w = sy_q + (HW'(1) << FRAC_BITS);
    mx_w  = $signed(mxr_w[FRAC_BITS+1 +: MW]);
    my_w  = $signed(myr_w[FRAC_BITS+1 +: MW]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx_q[ST_RND].room_x     <= ctx_q[ST_SUM].room_x;
      ctx_q[ST_RND].room_y     <= ctx_q[ST_SUM].room_y;
      ctx_q[ST_RND].center_x   <= ctx_q[ST_SUM].center_x;
      ctx_q[ST_RND].center_y   <= ctx_q[ST_SUM].center_y;
      ctx_q[ST_RND].mid_x      <= mx_w;
      ctx_q[ST_RND].mid_y      <= my_w;
      ctx_q[ST_RND].degenerate <= (mx_w == '0) && (my_w == '0);
    end
  end

  // plain context copy for every later stage
  for (genvar k = ST_ENC; k < ST_OUT; k++) begin : g_ctx
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ctx_q[k] <= ctx_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // ST_ENC: magnitudes and position of the leading one of the larger.
  // --------------------------------------------------------------------------
  logic signed [MW-1:0] amx_w, amy_w;
  logic [AW-1:0]        ax_w, ay_w, big_w;
  logic [POSW-1:0]      pos_w;
  logic [AW-1:0]        ax_q, ay_q;
  logic [POSW-1:0]      pos_q;

  always_comb begin
    amx_w = ctx_q[ST_RND].mid_x[MW-1] ? -ctx_q[ST_RND].mid_x : ctx_q[ST_RND].mid_x;
    amy_w = ctx_q[ST_RND].mid_y[MW-1] ? -ctx_q[ST_RND].mid_y : ctx_q[ST_RND].mid_y;
    ax_w  = amx_w[AW-1:0];
    ay_w  = amy_w[AW-1:0];
    big_w = (ax_w > ay_w) ? ax_w : ay_w;
    pos_w = '0;
    for (int i = 0; i < AW; i++) begin
      if (big_w[i]) begin
        pos_w = POSW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q  <= ax_w;
      ay_q  <= ay_w;
      pos_q <= pos_w;
    end
  end

  // ST_SHF: bring the larger magnitude into [2^29, 2^30); right shifts truncate
  logic [AW-1:0] shx_w, shy_w;
  logic [NW-1:0] nx_q, ny_q;

  always_comb begin
    if (pos_q >= POSW'(NORM_TOP)) begin
      shx_w = ax_q >> (pos_q - POSW'(NORM_TOP));
      shy_w = ay_q >> (pos_q - POSW'(NORM_TOP));
    end else begin
      shx_w = ax_q << (POSW'(NORM_TOP) - pos_q);
      shy_w = ay_q << (POSW'(NORM_TOP) - pos_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q <= shx_w[NW-1:0];
      ny_q <= shy_w[NW-1:0];
    end
  end

  // ST_SQR / ST_SSQ: squared length
  logic [2*NW-1:0] sqx_q, sqy_q;
  logic [NW-1:0]   nx5_q, ny5_q, nx6_q, ny6_q;
  logic [SQW-1:0]  ssum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q  <= nx_q * nx_q;
      sqy_q  <= ny_q * ny_q;
      nx5_q  <= nx_q;
      ny5_q  <= ny_q;
      ssum_q <= SQW'(sqx_q) + SQW'(sqy_q);
      nx6_q  <= nx5_q;
      ny6_q  <= ny5_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square root, one result bit per stage (remainder / root form).
  // --------------------------------------------------------------------------
  logic [SQW-1:0] sv_q  [0:SQ_STEPS-1];
  logic [SQW-1:0] sr_q  [0:SQ_STEPS-1];
  logic [NW-1:0]  snx_q [0:SQ_STEPS-1];
  logic [NW-1:0]  sny_q [0:SQ_STEPS-1];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [SQW-1:0] BitC = SQW'(1) << (2 * (SQ_STEPS - 1 - j));
    logic [SQW-1:0] v_in, r_in, t_w;
    logic [NW-1:0]  nx_in, ny_in;
    if (j == 0) begin : g_first
      assign v_in  = ssum_q;
      assign r_in  = '0;
      assign nx_in = nx6_q;
      assign ny_in = ny6_q;
    end else begin : g_next
      assign v_in  = sv_q[j-1];
      assign r_in  = sr_q[j-1];
      assign nx_in = snx_q[j-1];
      assign ny_in = sny_q[j-1];
    end
    assign t_w = r_in + BitC;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (v_in >= t_w) begin
          sv_q[j] <= v_in - t_w;
          sr_q[j] <= (r_in >> 1) + BitC;
        end else begin
          sv_q[j] <= v_in;
          sr_q[j] <= r_in >> 1;
        end
        snx_q[j] <= nx_in;
        sny_q[j] <= ny_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider: u = (n*2^F + r/2) / r, restoring, one quotient bit per stage.
  // Entry 0 is the setup stage that forms the numerators.
  // --------------------------------------------------------------------------
  logic [RW-1:0]   root_w;
  logic [NUMW-1:0] numx_w, numy_w;
  logic [RW-1:0]   den_q  [0:QW];
  logic [RW-1:0]   remx_q [0:QW];
  logic [RW-1:0]   remy_q [0:QW];
  logic [NUMW-1:0] nmx_q  [0:QW];
  logic [NUMW-1:0] nmy_q  [0:QW];
  logic [QW-1:0]   qx_q   [0:QW];
  logic [QW-1:0]   qy_q   [0:QW];

  assign root_w = sr_q[SQ_STEPS-1][RW-1:0];
  assign numx_w = {1'b0, snx_q[SQ_STEPS-1], {FRAC_BITS{1'b0}}} + NUMW'(root_w >> 1);
  assign numy_w = {1'b0, sny_q[SQ_STEPS-1], {FRAC_BITS{1'b0}}} + NUMW'(root_w >> 1);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q[0]  <= root_w;
      nmx_q[0]  <= numx_w;
      nmy_q[0]  <= numy_w;
      remx_q[0] <= RW'(numx_w >> QW);
      remy_q[0] <= RW'(numy_w >> QW);
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [RW:0] cx_w, cy_w;
    assign cx_w = {remx_q[j-1], nmx_q[j-1][QW-j]};
    assign cy_w = {remy_q[j-1], nmy_q[j-1][QW-j]};
    always_ff @(posedge clk_i) begin
      if (adv) begin
        den_q[j] <= den_q[j-1];
        nmx_q[j] <= nmx_q[j-1];
        nmy_q[j] <= nmy_q[j-1];
        if (cx_w >= {1'b0, den_q[j-1]}) begin
          remx_q[j] <= RW'(cx_w - {1'b0, den_q[j-1]});
          qx_q[j]   <= qx_q[j-1] | (QW'(1) << (QW - j));
        end else begin
          remx_q[j] <= cx_w[RW-1:0];
          qx_q[j]   <= qx_q[j-1];
        end
        if (cy_w >= {1'b0, den_q[j-1]}) begin
          remy_q[j] <= RW'(cy_w - {1'b0, den_q[j-1]});
          qy_q[j]   <= qy_q[j-1] | (QW'(1) << (QW - j));
        end else begin
          remy_q[j] <= cy_w[RW-1:0];
          qy_q[j]   <= qy_q[j-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // ST_USGN .. ST_OUT: signed direction, dot, projection, error, saturation.
  // --------------------------------------------------------------------------
  logic signed [UW-1:0]  qxs_w, qys_w;
  logic signed [UW-1:0]  ux_q, uy_q, ux1_q, uy1_q, ux2_q, uy2_q;
  logic signed [CPW-1:0] cpx_q, cpy_q;
  logic [DSW-1:0]        dsum_w;
  logic signed [DTW-1:0] dot_q;
  logic signed [PPW-1:0] ppx_q, ppy_q;
  logic [PPW-1:0]        psx_w, psy_w;
  logic signed [PJW-1:0] pjx_q, pjy_q;
  logic signed [EW-1:0]  tx_q, ty_q, ex_w, ey_w;
  out_item_t             res_w;

  assign qxs_w = $signed(UW'(qx_q[QW]));
  assign qys_w = $signed(UW'(qy_q[QW]));
  assign dsum_w = DSW'(cpx_q) + DSW'(cpy_q) + (DSW'(1) << (FRAC_BITS - 1));
  assign psx_w  = ppx_q + (PPW'(1) << (FRAC_BITS - 1));
  assign psy_w  = ppy_q + (PPW'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // take the sign of the midpoint back
      ux_q  <= ctx_q[ST_USGN-1].mid_x[MW-1] ? -qxs_w : qxs_w;
      uy_q  <= ctx_q[ST_USGN-1].mid_y[MW-1] ? -qys_w : qys_w;
      cpx_q <= ctx_q[ST_CMUL-1].center_x * ux_q;
      cpy_q <= ctx_q[ST_CMUL-1].center_y * uy_q;
      ux1_q <= ux_q;
      uy1_q <= uy_q;
      dot_q <= $signed(dsum_w[FRAC_BITS +: DTW]);
      ux2_q <= ux1_q;
      uy2_q <= uy1_q;
      ppx_q <= dot_q * ux2_q;
      ppy_q <= dot_q * uy2_q;
      pjx_q <= $signed(psx_w[FRAC_BITS +: PJW]);
      pjy_q <= $signed(psy_w[FRAC_BITS +: PJW]);
      tx_q  <= EW'(ctx_q[ST_ESUM-1].room_x) - EW'(ctx_q[ST_ESUM-1].center_x) + EW'(pjx_q);
      ty_q  <= EW'(ctx_q[ST_ESUM-1].room_y) - EW'(ctx_q[ST_ESUM-1].center_y) + EW'(pjy_q);
      res_q <= res_w;
    end
  end

  always_comb begin
    ex_w = tx_q - EW'(ctx_q[ST_OUT-1].mid_x);
    ey_w = ty_q - EW'(ctx_q[ST_OUT-1].mid_y);
    if (ex_w > SAT_HI) begin
      res_w.error_x = SAT_HI[WORD_BITS-1:0];
    end else if (ex_w < SAT_LO) begin
      res_w.error_x = SAT_LO[WORD_BITS-1:0];
    end else begin
      res_w.error_x = ex_w[WORD_BITS-1:0];
    end
    if (ey_w > SAT_HI) begin
      res_w.error_y = SAT_HI[WORD_BITS-1:0];
    end else if (ey_w < SAT_LO) begin
      res_w.error_y = SAT_LO[WORD_BITS-1:0];
    end else begin
      res_w.error_y = ey_w[WORD_BITS-1:0];
    end
    res_w.degenerate = ctx_q[ST_OUT-1].degenerate;
    // drop the errors of a zero-length midpoint
    if (ctx_q[ST_OUT-1].degenerate) begin
      res_w.error_x = '0;
      res_w.error_y = '0;
    end
  end

endmodule

// ===== test/room_center_from_two_walls_residual_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// room_center_from_two_walls_residual_unit_tb
// Self-checking bench for the two-wall room center residual unit.
// ----------------------------------------------------------------------------
// The bench drives directed corner words and then random words into the input
// channel. An in-bench fixed-point predictor computes each expected residual
// when its word is accepted. Every result word is checked in order against
// the oldest prediction. Both channels idle at random. One long receiver
// hold-off backs the pipeline up until the input stalls.
// ----------------------------------------------------------------------------
module room_center_from_two_walls_residual_unit_tb;
  import rcw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned RANDOM_WORDS = 650;
  localparam int unsigned HOLD_CYCLES = 400;

  // Scoreboard: predicts residuals and matches result words in order.
  class residual_scoreboard;
    out_item_t pending_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function longint round_q(longint v);
      return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    static function longint half_sum(longint p, longint q);
      return (p >>> 1) + (q >>> 1) + (p & q & 64'sd1);
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    static function longint saturate(longint v);
      longint hi;
      hi = (64'sd1 <<< (WORD_BITS - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    static function out_item_t residual(in_item_t w);
      longint n1x, n1y, d1, n2x, n2y, d2, cx, cy, rx, ry;
      longint mx, my, ux, uy, dot, ex, ey;
      longint unsigned ax, ay, big, r, qx, qy;
      int up, down;
      out_item_t res;
      n1x = w.wall_a_nx; n1y = w.wall_a_ny; d1 = w.wall_a_offset;
      n2x = w.wall_b_nx; n2y = w.wall_b_ny; d2 = w.wall_b_offset;
      cx = w.center_x; cy = w.center_y; rx = w.room_x; ry = w.room_y;
      res = '0;
      up = 0;
      down = 0;
      // flip any plane that faces away, then take offset magnitudes
      if (d1 > 0) begin n1x = -n1x; n1y = -n1y; d1 = -d1; end
      if (d2 > 0) begin n2x = -n2x; n2y = -n2y; d2 = -d2; end
      d1 = -d1;
      d2 = -d2;
      mx = round_q(half_sum(d1 * n1x, d2 * n2x));
      my = round_q(half_sum(d1 * n1y, d2 * n2y));
      if (mx == 0 && my == 0) begin
        res.degenerate = 1'b1;
        return res;
      end
      ax = (mx < 0) ? -mx : mx;
      ay = (my < 0) ? -my : my;
      big = (ax > ay) ? ax : ay;
      // bring the larger magnitude into [2^29, 2^30)
      while (big >= (64'd1 << 30)) begin big = big >> 1; down++; end
      while (big < (64'd1 << 29)) begin big = big << 1; up++; end
      ax = (ax >> down) << up;
      ay = (ay >> down) << up;
      r = int_sqrt(ax * ax + ay * ay);
      qx = ((ax << FRAC_BITS) + (r >> 1)) / r;
      qy = ((ay << FRAC_BITS) + (r >> 1)) / r;
      ux = (mx < 0) ? -longint'(qx) : longint'(qx);
      uy = (my < 0) ? -longint'(qy) : longint'(qy);
      dot = round_q(cx * ux + cy * uy);
      ex = rx - (mx + (cx - round_q(dot * ux)));
      ey = ry - (my + (cy - round_q(dot * uy)));
      res.error_x = WORD_BITS'(saturate(ex));
      res.error_y = WORD_BITS'(saturate(ey));
      return res;
    endfunction

    function void note_input(in_item_t w);
      pending_q.push_back(residual(w));
    endfunction

    task report(string what, longint got, longint want);
      mismatches++;
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.error_x !== want.error_x) report("error_x", got.error_x, want.error_x);
      if (got.error_y !== want.error_y) report("error_y", got.error_y, want.error_y);
      if (got.degenerate !== want.degenerate)
        report("degenerate", got.degenerate, want.degenerate);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  rcw_in_if  in_bus ();
  rcw_out_if out_bus ();

  residual_scoreboard board;
  int unsigned accepted;
  int unsigned cycles;
  bit calm;

  room_center_from_two_walls_residual_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a run that hangs.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one word and hold it until the block takes it.
  task drive_word(in_item_t w);
    in_bus.valid <= 1'b1;
    in_bus.data  <= w;
    do @(posedge clk_i); while (!in_bus.ready);
    board.note_input(w);
    accepted++;
    // drop valid for a random gap now and then
    if (!calm && $urandom_range(99) < 8) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  function automatic in_item_t make_word(int r0, int r1, int a0, int a1, int ad,
                                         int b0, int b1, int bd, int c0, int c1);
    in_item_t w;
    w.room_x = r0; w.room_y = r1;
    w.wall_a_nx = a0; w.wall_a_ny = a1; w.wall_a_offset = ad;
    w.wall_b_nx = b0; w.wall_b_ny = b1; w.wall_b_offset = bd;
    w.center_x = c0; w.center_y = c1;
    return w;
  endfunction

  function automatic int small_q(int unsigned span);
    return $signed($urandom_range(2 * span)) - $signed(span);
  endfunction

  // Well-formed walls: unit-scale normals, metre-scale offsets and positions.
  function automatic in_item_t plausible_word();
    in_item_t w;
    int nx;
    int ny;
    nx = small_q(65536);
    ny = small_q(65536);
    w.wall_a_nx = nx;
    w.wall_a_ny = ny;
    w.wall_a_offset = small_q(20 * 65536);
    // opposite wall: roughly the same normal, sometimes flipped
    w.wall_b_nx = ($urandom_range(1) ? nx : -nx) + small_q(2000);
    w.wall_b_ny = ($urandom_range(1) ? ny : -ny) + small_q(2000);
    w.wall_b_offset = small_q(20 * 65536);
    w.room_x = small_q(30 * 65536);
    w.room_y = small_q(30 * 65536);
    w.center_x = small_q(30 * 65536);
    w.center_y = small_q(30 * 65536);
    return w;
  endfunction

  function automatic in_item_t noise_word();
    in_item_t w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom};
    return w;
  endfunction

  // Receiver: random stalls, one calm stretch, one long hold-off.
  initial begin
    bit held;
    held = 1'b0;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) board.check_result(out_bus.data);
      if (!held && accepted >= 200) begin
        held = 1'b1;
        out_bus.ready <= 1'b0;
        // hold off while the sender keeps offering, so the input backs up
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_bus.ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin
    localparam int MAXI = 32'h7fffffff;
    localparam int MINI = 32'h80000000;
    localparam int ONE = 65536;
    board = new();
    accepted = 0;
    calm = 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.data  <= '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all zero: degenerate
    drive_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // opposite walls cancel exactly: degenerate with nonzero room
    drive_word(make_word(5 * ONE, -3, ONE, 0, -2 * ONE, -ONE, 0, -2 * ONE, ONE, ONE));
    // typical room, negative offsets
    drive_word(make_word(ONE, 2 * ONE, ONE, 0, -3 * ONE, -ONE, 0, -ONE, 0, ONE));
    // positive offsets force plane flips
    drive_word(make_word(0, ONE, 0, ONE, 4 * ONE, 0, -ONE, 2 * ONE, ONE, -ONE));
    // one offset zero
    drive_word(make_word(-ONE, 0, ONE, ONE, 0, 0, ONE, -ONE, 3, 7));
    // most negative offsets and normals: exact magnitudes
    drive_word(make_word(MINI, MINI, MINI, MINI, MINI, MINI, MINI, MINI, MINI, MINI));
    drive_word(make_word(MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI));
    drive_word(make_word(MAXI, MINI, MINI, MAXI, MAXI, MAXI, MINI, MINI, MAXI, MINI));
    drive_word(make_word(MINI, MAXI, MAXI, 0, MINI, 0, MAXI, MAXI, MINI, MAXI));
    // saturation of the error both ways
    drive_word(make_word(MAXI, MAXI, ONE, 0, -ONE, ONE, 0, -ONE, MINI, MINI));
    drive_word(make_word(MINI, MINI, ONE, 0, -ONE, ONE, 0, -ONE, MAXI, MAXI));
    // tiny midpoint: normalization shifts far up; the last two round to zero (degenerate)
    drive_word(make_word(0, 0, 1, 0, -ONE, 1, 0, -ONE, ONE, ONE));
    drive_word(make_word(0, 0, 0, 1, -1, 0, 0, 0, 0, 0));
    drive_word(make_word(0, 0, 1, 1, 1, 0, 0, 0, 0, 0));
    // all ones, all minus one
    drive_word(make_word(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    drive_word(make_word(1, 1, 1, 1, 1, 1, 1, 1, 1, 1));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= 400 && i < 520);
      drive_word(($urandom_range(99) < 75) ? plausible_word() : noise_word());
    end
    in_bus.valid <= 1'b0;
    calm = 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
